// ===== design/nps_pkg.sv =====
// Shared types and constants for the nearest-points selector.
`timescale 1ns / 1ps
`default_nettype none
package nps_pkg;

  // Field widths
  localparam int COORD_W        = 16;
  localparam int ABS_W          = 16;
  localparam int SQ_W           = 32;
  localparam int DIST_W         = 36;
  localparam int RANK_W         = 5;
  localparam int IN_TDATA_W     = 48;
  localparam int OUT_TDATA_W    = 56;
  localparam int CFG_ADDR_W     = 2;
  localparam int CFG_DATA_W     = 16;

  // Defaults for top-level parameters
  localparam int KEEP_COUNT_DEF = 32;
  localparam int FIFO_DEPTH_DEF = 4;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CAMERA_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CAMERA_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // Classified item handed from front to back
  typedef struct packed {
    point_t             pt;
    logic               last;
    logic [DIST_W-1:0]  distance;
  } item_t;

endpackage
`default_nettype wire

// ===== design/nps_front.sv =====
// Front end: takes points, holds the camera registers, computes squared distance.
`timescale 1ns / 1ps
`default_nettype none
module nps_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [nps_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [nps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [nps_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                            s_tlast,
  output logic                                 push,
  output nps_pkg::item_t                       item,
  input  wire logic                            full
);
  import nps_pkg::*;

  point_t                     camera;
  logic                       v1, v2;
  point_t                     p1, p2;
  logic                       l1, l2;
  logic [ABS_W-1:0]           ax, ay, az;
  logic [SQ_W-1:0]            sqx, sqy, sqz;
  logic                       load1, load2, adv2;
  logic signed [COORD_W:0]    dx, dy, dz;
  point_t                     pin;

  // Camera registers
  always_ff @(posedge clk) begin
    if (rst) begin
      camera <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CAMERA_X: camera.x <= cfg_data;
        REG_CAMERA_Y: camera.y <= cfg_data;
        REG_CAMERA_Z: camera.z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: stage 2 drains into the queue when it has room
  assign adv2     = v2 && !full;
  assign load2    = v1 && (!v2 || adv2);
  assign s_tready = !v1 || load2;
  assign load1    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (load1)      v1 <= 1'b1;
      else if (load2) v1 <= 1'b0;
      if (load2)      v2 <= 1'b1;
      else if (adv2)  v2 <= 1'b0;
    end
  end

  // Stage 1: coordinate differences, kept as magnitudes
  assign pin = point_t'(s_tdata);
  assign dx  = {pin.x[COORD_W-1], pin.x} - {camera.x[COORD_W-1], camera.x};
  assign dy  = {pin.y[COORD_W-1], pin.y} - {camera.y[COORD_W-1], camera.y};
  assign dz  = {pin.z[COORD_W-1], pin.z} - {camera.z[COORD_W-1], camera.z};

  always_ff @(posedge clk) begin
    if (load1) begin
      p1 <= pin;
      l1 <= s_tlast;
      ax <= dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
      ay <= dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
      az <= dz[COORD_W] ? ABS_W'(-dz) : ABS_W'(dz);
    end
  end

  // Stage 2: squares
  always_ff @(posedge clk) begin
    if (load2) begin
      p2  <= p1;
      l2  <= l1;
      sqx <= ax * ax;
      sqy <= ay * ay;
      sqz <= az * az;
    end
  end

  // Sum of squares goes straight into the queue
  assign push          = adv2;
  assign item.pt       = p2;
  assign item.last     = l2;
  assign item.distance = DIST_W'(sqx) + DIST_W'(sqy) + DIST_W'(sqz);

endmodule
`default_nettype wire

// ===== design/nps_fifo.sv =====
// Short queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module nps_fifo #(
  parameter int DEPTH = nps_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire nps_pkg::item_t wr_item,
  output logic                full,
  input  wire logic           pop,
  output nps_pkg::item_t      rd_item,
  output logic                valid
);
  import nps_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [AW-1:0]    wptr, rptr;
  logic [CW-1:0]    cnt;
  logic             do_push, do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign valid   = (cnt != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wr_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_pop)  rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (do_push && !do_pop)      cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== design/nps_back.sv =====
// Back end: sorted insertion chain of kept points and the frame drain.
`timescale 1ns / 1ps
`default_nettype none
module nps_back #(
  parameter int KEEP_COUNT = nps_pkg::KEEP_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_valid,
  input  wire nps_pkg::item_t                   q_item,
  output logic                                  q_pop,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [nps_pkg::OUT_TDATA_W-1:0]       m_tdata,
  output logic                                  m_tlast
);
  import nps_pkg::*;

  localparam int CW = $clog2(KEEP_COUNT + 1);
  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  point_t              pts  [KEEP_COUNT];
  logic [DIST_W-1:0]   dists[KEEP_COUNT];
  logic [CW-1:0]       count;
  logic                state;
  logic [RANK_W-1:0]   rank_cnt;
  logic [KEEP_COUNT-1:0] take;
  logic                ins, out_load;

  // Each cell decides if it lies at or beyond the insertion point
  always_comb begin
    for (int i = 0; i < KEEP_COUNT; i++) begin
      take[i] = (CW'(i) >= count) || (dists[i] > q_item.distance);
    end
  end

  assign q_pop    = (state == ST_FILL) && q_valid;
  assign ins      = q_pop && take[KEEP_COUNT-1];
  assign out_load = (state == ST_DRAIN) && (!m_tvalid || m_tready);

  // Cell row: shift up on insert, shift down while draining
  for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (out_load) begin
        if (i < KEEP_COUNT - 1) begin
          pts[i]   <= pts[(i < KEEP_COUNT - 1) ? i + 1 : i];
          dists[i] <= dists[(i < KEEP_COUNT - 1) ? i + 1 : i];
        end
      end else if (ins && take[i]) begin
        if (i == 0 || !take[(i > 0) ? i - 1 : 0]) begin
          pts[i]   <= q_item.pt;
          dists[i] <= q_item.distance;
        end else begin
          pts[i]   <= pts[(i > 0) ? i - 1 : 0];
          dists[i] <= dists[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  // Control: fill count, state and rank counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FILL;
      count    <= '0;
      rank_cnt <= '0;
    end else begin
      unique case (state)
        ST_FILL: begin
          if (ins && count != CW'(KEEP_COUNT)) count <= count + 1'b1;
          if (q_pop && q_item.last) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (out_load) begin
            count <= count - 1'b1;
            if (count == CW'(1)) begin
              state    <= ST_FILL;
              rank_cnt <= '0;
            end else begin
              rank_cnt <= rank_cnt + 1'b1;
            end
          end
        end
        default: state <= ST_FILL;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_TDATA_W'({rank_cnt, pts[0]});
      m_tlast <= (count == CW'(1));
    end
  end

  // Draining never starts on an empty list
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (count != '0))
    else $error("drain with empty list");

  // The final result ends the drain and empties the list
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && count == CW'(1)) |=> (state == ST_FILL && count == '0))
    else $error("drain did not end after final result");

  // An insert into a list with room grows it by one
  a_grow: assert property (@(posedge clk) disable iff (rst)
    (ins && count != CW'(KEEP_COUNT)) |=> (count == $past(count) + 1'b1))
    else $error("fill count not advanced on insert");

endmodule
`default_nettype wire

// ===== design/nearest_points_select.sv =====
// Top level of the nearest-points selector.
//
// Streams one 3D point per item on the s_ side (x, y, z in s_tdata, frame end
// on s_tlast) and keeps the KEEP_COUNT points nearest the camera position,
// ranked by exact squared distance; ties keep arrival order. After the item
// flagged with s_tlast is taken in, the kept points leave on the m_ side
// nearest first, one item per cycle while m_tready is high, with their rank,
// m_tlast on the last. Camera registers are written through cfg_we /
// cfg_addr / cfg_data. A point passes the two front stages and then the
// queue, and is inserted into the sorted list as it leaves the queue; once
// the flagged point is inserted, the first result is loaded into the output
// register. Points are taken in one per cycle outside a frame drain, each
// inserted into the row of cells as it leaves the queue; during a drain the
// input fills the queue and then stalls. Reset clears the camera to zero,
// empties the list and the queue. A stalled receiver holds the output
// register and the drain waits; new points keep entering until the queue is
// full.
`timescale 1ns / 1ps
`default_nettype none
module nearest_points_select #(
  parameter int KEEP_COUNT = nps_pkg::KEEP_COUNT_DEF,
  parameter int FIFO_DEPTH = nps_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [nps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [nps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // point_x [15:0], point_y [31:16], point_z [47:32]
  input  wire logic [nps_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // out_x [15:0], out_y [31:16], out_z [47:32], rank [52:48], zero fill
  output logic [nps_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                   m_tlast
);
  import nps_pkg::*;

  logic   push, full, pop, q_valid;
  item_t  wr_item, rd_item;

  nps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .push     (push),
    .item     (wr_item),
    .full     (full)
  );

  nps_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .full    (full),
    .pop     (pop),
    .rd_item (rd_item),
    .valid   (q_valid)
  );

  nps_back #(.KEEP_COUNT(KEEP_COUNT)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (rd_item),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for nearest_points_select: sorted k-nearest output per frame.
`timescale 1ns / 1ps
module tb;
  import nps_pkg::*;

  localparam int KEEP = KEEP_COUNT_DEF;

  // Expected output item: a kept point with its rank and end-of-frame flag
  typedef struct {
    point_t            pt;
    logic [RANK_W-1:0] rank;
    logic              is_last;
  } ranked_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // point_x [15:0], point_y [31:16], point_z [47:32]
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // out_x [15:0], out_y [31:16], out_z [47:32], rank [52:48], zero fill
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  nearest_points_select dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor state: camera copy and the sorted list of kept points
  point_t            cam = '0;
  point_t            kept_pts [KEEP];
  logic [DIST_W-1:0] kept_dist [KEEP];
  int                kept_n = 0;
  ranked_t           ranked_q [$];

  int bad_count = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_wait = 0;

  // Exact squared distance from the camera
  function automatic logic [DIST_W-1:0] sq_dist(point_t p);
    longint dx, dy, dz;
    dx = longint'($signed(p.x)) - longint'($signed(cam.x));
    dy = longint'($signed(p.y)) - longint'($signed(cam.y));
    dz = longint'($signed(p.z)) - longint'($signed(cam.z));
    return DIST_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Insert one accepted point; on the frame end, queue the sorted list
  task automatic rank_point(input point_t p, input bit is_last);
    logic [DIST_W-1:0] d;
    int pos, top, i;
    ranked_t r;
    d = sq_dist(p);
    pos = 0;
    // ties keep arrival order: skip every entry not farther than d
    while (pos < kept_n && kept_dist[pos] <= d) pos++;
    if (pos < KEEP) begin
      top = (kept_n < KEEP) ? kept_n : KEEP - 1;
      for (i = top; i > pos; i--) begin
        kept_dist[i] = kept_dist[i-1];
        kept_pts[i]  = kept_pts[i-1];
      end
      kept_dist[pos] = d;
      kept_pts[pos]  = p;
      if (kept_n < KEEP) kept_n++;
    end
    if (is_last) begin
      for (i = 0; i < kept_n; i++) begin
        r.pt      = kept_pts[i];
        r.rank    = RANK_W'(i);
        r.is_last = (i == kept_n - 1);
        ranked_q.push_back(r);
      end
      kept_n = 0;
    end
  endtask

  // Send one item; called at a falling edge, returns at a falling edge
  task automatic send_point(input point_t p, input bit is_last);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= p;
    s_tlast  <= is_last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    rank_point(p, is_last);
    @(negedge clk);
  endtask

  // Stop sending, wait for every expected item, then let the pipe empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (ranked_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // Write all three camera registers; block must be idle
  task automatic set_camera(input point_t c);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_CAMERA_X;
    cfg_data <= c.x;
    @(negedge clk);
    cfg_addr <= REG_CAMERA_Y;
    cfg_data <= c.y;
    @(negedge clk);
    cfg_addr <= REG_CAMERA_Z;
    cfg_data <= c.z;
    @(negedge clk);
    cfg_we <= 1'b0;
    cam = c;
  endtask

  // 0: any value, 1: within 3 of centre (clamped), 2: the extremes or -1, 0, 1
  function automatic logic signed [COORD_W-1:0] random_coord(input int mode,
                                                            input logic signed [COORD_W-1:0] centre);
    int v;
    case (mode)
      1: begin
        v = int'(centre) + int'($urandom_range(0, 6)) - 3;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      2: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = -1;
          2: v = 0;
          3: v = 1;
          default: v = 32767;
        endcase
      end
      default: v = int'($urandom_range(0, 65535));
    endcase
    return v[COORD_W-1:0];
  endfunction

  // Receiver: ready drops for a random number of cycles after each item
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      m_tready <= 1'b0;
      rx_wait  = rx_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Output check against the oldest expected item
  always @(posedge clk) begin
    ranked_t e;
    point_t  got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[IN_TDATA_W-1:0];
      if (ranked_q.size() == 0) begin
        $error("unexpected output item: x %0d y %0d z %0d", got.x, got.y, got.z);
        bad_count++;
      end else begin
        e = ranked_q.pop_front();
        if (got.x !== e.pt.x) begin
          $error("out_x: expected %0d, got %0d", e.pt.x, got.x);
          bad_count++;
        end
        if (got.y !== e.pt.y) begin
          $error("out_y: expected %0d, got %0d", e.pt.y, got.y);
          bad_count++;
        end
        if (got.z !== e.pt.z) begin
          $error("out_z: expected %0d, got %0d", e.pt.z, got.z);
          bad_count++;
        end
        if (m_tdata[IN_TDATA_W +: RANK_W] !== e.rank) begin
          $error("rank: expected %0d, got %0d", e.rank, m_tdata[IN_TDATA_W +: RANK_W]);
          bad_count++;
        end
        if (m_tlast !== e.is_last) begin
          $error("final_result: expected %0d, got %0d", e.is_last, m_tlast);
          bad_count++;
        end
      end
      rx_wait = rx_idle_en ? $urandom_range(0, 17) : 0;
    end
  end

  // Extreme coordinates against extreme camera positions
  task automatic test_extremes();
    send_point('{z: 16'sd32767, y: 16'sd32767, x: 16'sd32767}, 1'b1);
    settle();
    set_camera('{z: 16'sd32767, y: 16'sd32767, x: 16'sd32767});
    send_point('{z: -16'sd32768, y: -16'sd32768, x: -16'sd32768}, 1'b0);
    send_point('{z: 16'sd32767, y: 16'sd32767, x: 16'sd32767}, 1'b0);
    send_point('{z: 16'sd0, y: 16'sd0, x: 16'sd0}, 1'b1);
    settle();
    set_camera('{z: -16'sd32768, y: -16'sd32768, x: -16'sd32768});
    send_point('{z: 16'sd0, y: -16'sd32768, x: 16'sd32767}, 1'b1);
    settle();
  endtask

  // Equal distances must come out in arrival order
  task automatic test_ties();
    set_camera('0);
    send_point('{z: 16'sd0, y: 16'sd4, x: 16'sd3}, 1'b0);
    send_point('{z: 16'sd5, y: 16'sd0, x: 16'sd0}, 1'b0);
    send_point('{z: 16'sd1, y: 16'sd1, x: 16'sd1}, 1'b0);
    send_point('{z: 16'sd3, y: 16'sd0, x: 16'sd4}, 1'b0);
    send_point('{z: 16'sd0, y: -16'sd5, x: 16'sd0}, 1'b1);
    settle();
  endtask

  // Camera moves mid-frame: kept distances stay, later points use the new camera
  task automatic test_camera_mid_frame();
    send_point('{z: 16'sd0, y: 16'sd0, x: 16'sd10}, 1'b0);
    send_point('{z: 16'sd0, y: 16'sd0, x: 16'sd20}, 1'b0);
    settle();
    set_camera('{z: 16'sd0, y: 16'sd0, x: 16'sd20});
    send_point('{z: 16'sd0, y: 16'sd0, x: 16'sd0}, 1'b1);
    settle();
  endtask

  // Random frames of varied size, content and pacing
  task automatic test_random_frames();
    int sent, size, mode, cmode, i;
    point_t p, c;
    sent = 0;
    while (sent < 400) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        cmode = ($urandom_range(0, 2) == 0) ? 2 : 0;
        c.x = random_coord(cmode, '0);
        c.y = random_coord(cmode, '0);
        c.z = random_coord(cmode, '0);
        set_camera(c);
      end else if ($urandom_range(0, 5) == 0) begin
        settle();
      end
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0, 1: mode = 0;
        2, 3: mode = 1;
        default: mode = 2;
      endcase
      case ($urandom_range(0, 9))
        0: size = $urandom_range(1, 3);
        1, 2: size = $urandom_range(33, 60);
        default: size = $urandom_range(1, 40);
      endcase
      for (i = 0; i < size; i++) begin
        p.x = random_coord(mode, cam.x);
        p.y = random_coord(mode, cam.y);
        p.z = random_coord(mode, cam.z);
        send_point(p, i == size - 1);
      end
      sent += size;
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_extremes();
    test_ties();
    test_camera_mid_frame();
    test_random_frames();
    settle();
    if (bad_count == 0) begin
      $display("nearest_points_select: match");
    end else begin
      $display("nearest_points_select: mismatch");
    end
    $finish;
  end

  // Run limit
  initial begin
    #50_000_000;
    $display("nearest_points_select: mismatch");
    $finish;
  end

endmodule

// ===== nearest_points_select.f =====
design/nps_pkg.sv
design/nps_front.sv
design/nps_fifo.sv
design/nps_back.sv
design/nearest_points_select.sv
tb/tb.sv
